// ===== rtl/jpeg_exif_strip_filter_assert.svh =====
// assertion macros for the exif strip filter checks
`ifndef JPEG_EXIF_STRIP_FILTER_ASSERT_SVH
`define JPEG_EXIF_STRIP_FILTER_ASSERT_SVH

// same-cycle implication
`define JES_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jes check failed");

// next-cycle implication
`define JES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jes check failed");

`endif

// ===== rtl/jes_pkg.sv =====
// shared types, constants and the exif tag table for the exif strip filter
package jes_pkg;

   localparam int MaxItems = 10;
   localparam int CountWidth = $clog2(MaxItems + 1);

   localparam logic [7:0] MarkPrefix = 8'hFF;
   localparam logic [7:0] MarkSoi    = 8'hD8;
   localparam logic [7:0] MarkEoi    = 8'hD9;
   localparam logic [7:0] MarkSos    = 8'hDA;
   localparam logic [7:0] MarkTem    = 8'h01;
   localparam logic [7:0] MarkRst0   = 8'hD0;
   localparam logic [7:0] MarkRst7   = 8'hD7;
   localparam logic [7:0] MarkApp1   = 8'hE1;
   localparam logic [2:0] TagLength  = 3'd6;
   localparam logic [15:0] MinExifLength = 16'd8;

   typedef enum logic [3:0] {
      PH_SOI0,
      PH_SOI1,
      PH_MARK0,
      PH_MARK1,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_A_LEN_HI,
      PH_A_LEN_LO,
      PH_A_MAGIC,
      PH_BODY,
      PH_SKIP,
      PH_PASS,
      PH_ERR
   } phase_type;

   // words produced by one input byte
   typedef struct packed {
      logic [MaxItems-1:0][7:0] data;
      logic [CountWidth-1:0]    count;
      logic                     eos;
      logic                     bare;
      logic                     err;
   } group_type;

   // "Exif" 00 00
   function automatic logic [7:0] exif_tag(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'h45;
         3'd1: val = 8'h78;
         3'd2: val = 8'h69;
         3'd3: val = 8'h66;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/jes_parse.sv =====
// marker segment parser: parse state and the word group for one byte
module jes_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                last_byte,
   output jes_pkg::group_type  group
);

   jes_pkg::phase_type phase_ff, phase_in;
   logic [15:0] rem_ff, rem_in;
   logic [2:0]  mm_ff, mm_in;
   logic [2:0]  seen_ff, seen_in;

   logic [jes_pkg::MaxItems-1:0][7:0] items;
   logic [jes_pkg::CountWidth-1:0]    n;
   logic [15:0] rem_dec;
   logic [15:0] len;
   logic [15:0] len_rem;
   logic [15:0] mag_len;
   logic [2:0]  m;
   logic        good;

   // next parse state and emitted words
   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      mm_in    = mm_ff;
      seen_in  = (seen_ff < 3'd4) ? seen_ff + 3'd1 : seen_ff;
      items    = '0;
      n        = '0;
      rem_dec  = rem_ff - 16'd1;
      len      = {rem_ff[15:8], in_byte};
      len_rem  = len - 16'd2;
      mag_len  = rem_ff + {13'd0, mm_ff} + 16'd2;
      m        = (mm_ff > 3'd5) ? 3'd5 : mm_ff;

      case (phase_ff)
         jes_pkg::PH_SOI0: begin
            if (in_byte == jes_pkg::MarkPrefix) begin
               items[0] = in_byte;
               n        = jes_pkg::CountWidth'(1);
               phase_in = jes_pkg::PH_SOI1;
            end else begin
               phase_in = jes_pkg::PH_ERR;
            end
         end
         jes_pkg::PH_SOI1: begin
            if (in_byte == jes_pkg::MarkSoi) begin
               items[0] = in_byte;
               n        = jes_pkg::CountWidth'(1);
               phase_in = jes_pkg::PH_MARK0;
            end else begin
               phase_in = jes_pkg::PH_ERR;
            end
         end
         jes_pkg::PH_MARK0: begin
            phase_in = (in_byte == jes_pkg::MarkPrefix) ? jes_pkg::PH_MARK1 : jes_pkg::PH_ERR;
         end
         jes_pkg::PH_MARK1: begin
            items[0] = jes_pkg::MarkPrefix;
            items[1] = in_byte;
            n        = jes_pkg::CountWidth'(2);
            if (in_byte == jes_pkg::MarkEoi || in_byte == jes_pkg::MarkSos) begin
               phase_in = jes_pkg::PH_PASS;
            end else if (in_byte == jes_pkg::MarkTem ||
                         (in_byte >= jes_pkg::MarkRst0 && in_byte <= jes_pkg::MarkRst7)) begin
               phase_in = jes_pkg::PH_MARK0;
            end else if (in_byte == jes_pkg::MarkApp1) begin
               // hold the app1 marker until the tag is known
               items    = '0;
               n        = '0;
               phase_in = jes_pkg::PH_A_LEN_HI;
            end else begin
               phase_in = jes_pkg::PH_LEN_HI;
            end
         end
         jes_pkg::PH_LEN_HI: begin
            rem_in   = {in_byte, 8'h00};
            items[0] = in_byte;
            n        = jes_pkg::CountWidth'(1);
            phase_in = jes_pkg::PH_LEN_LO;
         end
         jes_pkg::PH_A_LEN_HI: begin
            rem_in   = {in_byte, 8'h00};
            phase_in = jes_pkg::PH_A_LEN_LO;
         end
         jes_pkg::PH_LEN_LO: begin
            if (len < 16'd2) begin
               phase_in = jes_pkg::PH_ERR;
            end else begin
               rem_in   = len_rem;
               items[0] = in_byte;
               n        = jes_pkg::CountWidth'(1);
               phase_in = (len_rem == 16'd0) ? jes_pkg::PH_MARK0 : jes_pkg::PH_BODY;
            end
         end
         jes_pkg::PH_A_LEN_LO: begin
            if (len < 16'd2) begin
               phase_in = jes_pkg::PH_ERR;
            end else if (len >= jes_pkg::MinExifLength) begin
               rem_in   = len_rem;
               mm_in    = 3'd0;
               phase_in = jes_pkg::PH_A_MAGIC;
            end else begin
               // too short for exif: release marker and length now
               rem_in   = len_rem;
               items[0] = jes_pkg::MarkPrefix;
               items[1] = jes_pkg::MarkApp1;
               items[2] = len[15:8];
               items[3] = in_byte;
               n        = jes_pkg::CountWidth'(4);
               phase_in = (len_rem == 16'd0) ? jes_pkg::PH_MARK0 : jes_pkg::PH_BODY;
            end
         end
         jes_pkg::PH_A_MAGIC: begin
            rem_in = rem_dec;
            if (mm_ff < jes_pkg::TagLength && in_byte == jes_pkg::exif_tag(mm_ff)) begin
               if (mm_ff == jes_pkg::TagLength - 3'd1) begin
                  mm_in    = 3'd0;
                  phase_in = (rem_dec == 16'd0) ? jes_pkg::PH_MARK0 : jes_pkg::PH_SKIP;
               end else begin
                  mm_in    = mm_ff + 3'd1;
                  phase_in = (rem_dec == 16'd0) ? jes_pkg::PH_ERR : jes_pkg::PH_A_MAGIC;
               end
            end else begin
               // tag mismatch: flush marker, length, matched tag bytes and this byte
               items[0] = jes_pkg::MarkPrefix;
               items[1] = jes_pkg::MarkApp1;
               items[2] = mag_len[15:8];
               items[3] = mag_len[7:0];
               for (int k = 4; k < jes_pkg::MaxItems; k++) begin
                  if (3'(k - 4) < m) begin
                     items[k] = jes_pkg::exif_tag(3'(k - 4));
                  end else if (3'(k - 4) == m) begin
                     items[k] = in_byte;
                  end
               end
               n        = jes_pkg::CountWidth'(5) + jes_pkg::CountWidth'(m);
               mm_in    = 3'd0;
               phase_in = (rem_dec == 16'd0) ? jes_pkg::PH_MARK0 : jes_pkg::PH_BODY;
            end
         end
         jes_pkg::PH_BODY: begin
            rem_in   = rem_dec;
            items[0] = in_byte;
            n        = jes_pkg::CountWidth'(1);
            phase_in = (rem_dec == 16'd0) ? jes_pkg::PH_MARK0 : jes_pkg::PH_BODY;
         end
         jes_pkg::PH_SKIP: begin
            rem_in   = rem_dec;
            phase_in = (rem_dec == 16'd0) ? jes_pkg::PH_MARK0 : jes_pkg::PH_SKIP;
         end
         jes_pkg::PH_PASS: begin
            items[0] = in_byte;
            n        = jes_pkg::CountWidth'(1);
         end
         default: begin
            phase_in = jes_pkg::PH_ERR;
         end
      endcase

      // a fault suppresses all data words
      if (phase_in == jes_pkg::PH_ERR) begin
         n = '0;
      end

      good = (seen_in >= 3'd4) &&
             (phase_in == jes_pkg::PH_MARK0 || phase_in == jes_pkg::PH_PASS);

      group.data  = items;
      group.count = n;
      group.eos   = 1'b0;
      group.bare  = 1'b0;
      group.err   = 1'b0;

      // end of stream: flag the last word or send a bare end word, then restart
      if (last_byte) begin
         group.eos = 1'b1;
         if (!(good && n != '0)) begin
            group.data  = '0;
            group.count = jes_pkg::CountWidth'(1);
            group.bare  = 1'b1;
            group.err   = !good;
         end
         phase_in = jes_pkg::PH_SOI0;
         rem_in   = '0;
         mm_in    = '0;
         seen_in  = '0;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jes_pkg::PH_SOI0;
         rem_ff   <= '0;
         mm_ff    <= '0;
         seen_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         mm_ff    <= mm_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== rtl/jes_drain.sv =====
// result register: holds one word group and hands it out one word per cycle while not stalled
module jes_drain (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jes_pkg::group_type  group,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_present,
   output logic                rsp_end_of_stream,
   output logic                rsp_decode_error
);

   logic [jes_pkg::MaxItems-1:0][7:0] data_ff;
   logic [jes_pkg::CountWidth-1:0]    cnt_ff;
   logic eos_ff, bare_ff, err_ff;
   logic take;

   // handshake and group turnover
   assign take     = (cnt_ff != '0) && !rsp_stall;
   assign can_load = (cnt_ff == '0) ||
                     (cnt_ff == jes_pkg::CountWidth'(1) && !rsp_stall);

   // word count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= group.count;
      end else if (take) begin
         cnt_ff <= cnt_ff - jes_pkg::CountWidth'(1);
      end
   end

   // word data, shifted down as words leave
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= group.data;
         eos_ff  <= group.eos;
         bare_ff <= group.bare;
         err_ff  <= group.err;
      end else if (take) begin
         data_ff <= {8'h00, data_ff[jes_pkg::MaxItems-1:1]};
      end
   end

   // result word
   assign rsp_valid         = cnt_ff != '0;
   assign rsp_out_byte      = data_ff[0];
   assign rsp_byte_present  = !bare_ff;
   assign rsp_end_of_stream = eos_ff && (cnt_ff == jes_pkg::CountWidth'(1));
   assign rsp_decode_error  = err_ff;

endmodule

// ===== rtl/jpeg_exif_strip_filter.sv =====
// top level of the jpeg exif strip filter
//
// Takes a JPEG stream one byte per word on the req channel (req_last_byte on
// the final byte) and returns the stream with Exif APP1 segments removed on
// the rsp channel. Both channels are valid/stall: a word moves at a clock
// edge with valid high and stall low.
// A byte accepted into the input register is parsed combinationally and
// its word group loaded into the result register, from which its first
// word is shown. Throughput: one byte per cycle while each byte yields at
// most one word and the receiver does not stall. A byte that yields more
// words holds the input register until its last word is taken, since the
// result register hands out one word per cycle while not stalled (a
// released marker is two words, a flushed APP1 header up to ten).
// A malformed stream gives no further data and ends with a bare word with
// rsp_decode_error set; the receiver drops what it already got.
// Reset (synchronous) empties both registers and returns the parser to the
// start of a stream. A stalled receiver holds the current word; the input
// side stalls while the input register is full and cannot pass its byte on.
module jpeg_exif_strip_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_end_of_stream,
   output logic       rsp_decode_error
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       can_load;
   logic       advance;
   logic       accept;
   jes_pkg::group_type group;

   // input register handshake
   assign advance   = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // parser
   jes_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .group     (group)
   );

   // result register
   jes_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .load              (advance),
      .group             (group),
      .can_load          (can_load),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_present  (rsp_byte_present),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_decode_error  (rsp_decode_error)
   );

endmodule

// ===== rtl/jes_checker.sv =====
// port checks for the exif strip filter and their bind
`include "jpeg_exif_strip_filter_assert.svh"

module jes_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_present,
   input logic       rsp_end_of_stream,
   input logic       rsp_decode_error
);

   logic        rsp_wait;
   logic        rsp_err;
   logic        rsp_bare;
   logic [10:0] rsp_word;

   // qualified views of the result word
   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_err  = rsp_valid && rsp_decode_error;
   assign rsp_bare = rsp_valid && !rsp_byte_present;
   assign rsp_word = {rsp_out_byte, rsp_byte_present, rsp_end_of_stream, rsp_decode_error};

   // a stalled result word stays up and unchanged
   `JES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_word))

   // an error is only reported on a bare end word
   `JES_ASSERT_IMPLY(a_err_bare_end, clock, reset, rsp_err, rsp_end_of_stream && !rsp_byte_present)

   // a word without data only ever ends a stream
   `JES_ASSERT_IMPLY(a_bare_is_end, clock, reset, rsp_bare, rsp_end_of_stream)

   // a bare word carries a zero byte
   `JES_ASSERT_IMPLY(a_bare_zero, clock, reset, rsp_bare, rsp_out_byte == 8'h00)

   // reset leaves no result pending and the input open
   `JES_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind jpeg_exif_strip_filter jes_checker u_jes_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_byte_present  (rsp_byte_present),
   .rsp_end_of_stream (rsp_end_of_stream),
   .rsp_decode_error  (rsp_decode_error)
);
